FILE: rtl/gdfb_pkg.sv
// ---------------------------------------------------------------------------
// gdfb_pkg: shared definitions for the gate display frame buffer
// Panel geometry, store sizing, opcodes, the bit mask table and the structs
// passed between the sequencer, the pixel decoder and the scan buffer.
// ---------------------------------------------------------------------------
`default_nettype none

package gdfb_pkg;

  // Panel geometry. ROWS is fixed by the byte layout (two rows per bit pair).
  localparam int COLUMNS     = 192;
  localparam int ROWS        = 16;
  localparam int HALF_BYTES  = (COLUMNS / 8) * ROWS;
  localparam int STORE_BYTES = 2 * HALF_BYTES;
  localparam int BURST       = 8;
  localparam int GATES       = HALF_BYTES / BURST;

  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int XR_W   = $clog2(COLUMNS);
  localparam int LA_W   = XR_W + 1;
  localparam int GATE_W = 6;
  localparam int BEAT_W = $clog2(BURST);

  typedef enum logic [1:0] {
    OP_DRAW    = 2'd0,
    OP_FILL    = 2'd1,
    OP_SWAP    = 2'd2,
    OP_REFRESH = 2'd3
  } opcode_t;

  // Bit within a byte, indexed by {xr[2:0], y[0]}.
  localparam logic [7:0] MASK_TABLE [16] = '{
    8'h10, 8'h01, 8'h20, 8'h02, 8'h40, 8'h04, 8'h80, 8'h08,
    8'h20, 8'h02, 8'h10, 8'h01, 8'h80, 8'h08, 8'h40, 8'h04
  };

  // Decoded pixel location within one half.
  typedef struct packed {
    logic            hit;
    logic [LA_W-1:0] addr;
    logic [7:0]      mask;
  } pix_loc_t;

  // One write to the frame store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  // One scan read issued to the store, with the tags that go with its byte.
  typedef struct packed {
    logic              valid;
    logic [GATE_W-1:0] gate;
    logic              last_in_burst;
  } scan_req_t;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic [GATE_W-1:0] gate_number;
    logic              gate_serial_in;
    logic              blank_select;
    logic              last_in_burst;
    logic              last_in_frame;
  } beat_t;

endpackage

`default_nettype wire

FILE: rtl/gdfb_if.sv
// ---------------------------------------------------------------------------
// gdfb_if: command and burst channels
// Valid/ready channels; an item moves on a clock edge with both high.
// ---------------------------------------------------------------------------
`default_nettype none

interface gdfb_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [8:0] pixel_x;
  logic [5:0] pixel_y;
  logic       color;

  modport source (output valid, opcode, pixel_x, pixel_y, color, input ready);
  modport sink   (input valid, opcode, pixel_x, pixel_y, color, output ready);
endinterface

interface gdfb_burst_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [5:0] gate_number;
  logic       gate_serial_in;
  logic       blank_select;
  logic       last_in_burst;
  logic       last_in_frame;

  modport source (output valid, data_byte, gate_number, gate_serial_in, blank_select,
                  last_in_burst, last_in_frame, input ready);
  modport sink   (input valid, data_byte, gate_number, gate_serial_in, blank_select,
                  last_in_burst, last_in_frame, output ready);
endinterface

`default_nettype wire

FILE: rtl/gate_display_frame_buffer.sv
// ---------------------------------------------------------------------------
// gate_display_frame_buffer: double-half frame buffer for a gate-scanned panel
// Draw, fill, swap and refresh commands against a byte store of two halves.
// ---------------------------------------------------------------------------
// After reset the block runs a clearing pass, one byte a cycle over both
// halves, and accepts no command until it ends. Commands are then taken one
// at a time on the cmd channel. A swap is done at acceptance. A pixel draw
// steps through accept, read and write back, because the bit is set or
// cleared by a read-modify-write of one byte in the single-read,
// single-write store; a draw that lies off the panel ends at acceptance. A
// fill writes one byte of the active half per cycle. A refresh accepts, then
// issues one store read per byte, the eight reads of the next gate, one per
// cycle while the buffer has room. Its bytes leave through a two-item
// buffer, so a stalled panel side slows the reads but loses nothing, and the
// next command may be accepted while bytes are still waiting.
// Draws, fills and scan reads all work on the active half.
// ---------------------------------------------------------------------------
`default_nettype none

module gate_display_frame_buffer
  import gdfb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  gdfb_cmd_if.sink     cmd,
  gdfb_burst_if.source burst
);

  pix_loc_t          loc;
  mem_wr_t           wr;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;
  logic              room;
  scan_req_t         req;

  // Pixel coordinates are decoded straight from the command payload; the
  // sequencer samples the result when it accepts a draw.
  gdfb_pix_decode u_decode (
    .pixel_x (cmd.pixel_x),
    .pixel_y (cmd.pixel_y),
    .loc     (loc)
  );

  gdfb_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .loc   (loc),
    .rdata (rdata),
    .room  (room),
    .wr    (wr),
    .raddr (raddr),
    .req   (req)
  );

  // Both halves live in one store; the upper half starts at byte 384.
  gdfb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (raddr),
    .rdata (rdata)
  );

  // The buffer tags each returning byte and grants a read only when it will
  // have room to hold the byte that the read returns.
  gdfb_scan_buf u_buf (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rdata (rdata),
    .room  (room),
    .burst (burst)
  );

endmodule

`default_nettype wire

FILE: rtl/gdfb_ram.sv
// ---------------------------------------------------------------------------
// gdfb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module gdfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/gdfb_pix_decode.sv
// ---------------------------------------------------------------------------
// gdfb_pix_decode: pixel coordinate to byte address and bit mask
// Clips off-panel pixels, rotates the column by two and looks up the mask.
// ---------------------------------------------------------------------------
`default_nettype none

module gdfb_pix_decode
  import gdfb_pkg::*;
(
  input  wire logic [8:0] pixel_x,
  input  wire logic [5:0] pixel_y,
  output pix_loc_t        loc
);

  logic            x_on;
  logic            y_on;
  logic [8:0]      xr_wide;
  logic [XR_W-1:0] xr;
  logic [2:0]      row;
  logic            in_half;

  always_comb begin
    x_on = !pixel_x[8] && ({1'b0, pixel_x[7:0]} < 9'(COLUMNS));
    y_on = !pixel_y[5] && (pixel_y < 6'(ROWS));
    // Column rotation: the first two columns wrap to the far end.
    if (pixel_x[7:0] < 8'd2) begin
      xr_wide = pixel_x + 9'(COLUMNS - 2);
    end else begin
      xr_wide = pixel_x - 9'd2;
    end
    xr = xr_wide[XR_W-1:0];
    // (17 - y) / 2 - 1 for y in 0..15 is the inverse of y[3:1].
    row      = ~pixel_y[3:1];
    loc.addr = {xr[XR_W-1:2], row};
    in_half  = 32'(loc.addr) < HALF_BYTES;
    loc.hit  = x_on && y_on && in_half;
    loc.mask = MASK_TABLE[{xr[2:0], pixel_y[0]}];
  end

endmodule

`default_nettype wire

FILE: rtl/gdfb_scan_buf.sv
// ---------------------------------------------------------------------------
// gdfb_scan_buf: scan-out byte buffer
// Pairs each returning store byte with its gate tags and holds up to two
// bytes so that the panel side can stall without losing data.
// ---------------------------------------------------------------------------
`default_nettype none

module gdfb_scan_buf
  import gdfb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire scan_req_t  req,
  input  wire logic [7:0] rdata,
  output logic            room,
  gdfb_burst_if.source    burst
);

  logic      pend_valid;
  scan_req_t pend;
  logic      head_valid;
  beat_t     head;
  logic      skid_valid;
  beat_t     skid;
  beat_t     arr;
  logic      pop;
  logic [1:0] fill;

  always_comb begin
    arr.data_byte      = rdata;
    arr.gate_number    = pend.gate;
    arr.gate_serial_in = pend.gate < GATE_W'(2);
    arr.blank_select   = pend.gate[0];
    arr.last_in_burst  = pend.last_in_burst;
    arr.last_in_frame  = pend.last_in_burst && (pend.gate == GATE_W'(GATES - 1));
    pop  = head_valid && burst.ready;
    fill = 2'(head_valid) + 2'(skid_valid) + 2'(pend_valid);
    room = (fill < 2'd2) || pop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      pend_valid <= req.valid;
      if (pop) begin
        head_valid <= skid_valid || pend_valid;
        skid_valid <= skid_valid && pend_valid;
      end else if (!head_valid) begin
        head_valid <= pend_valid;
      end else if (pend_valid) begin
        skid_valid <= 1'b1;
      end
    end
    pend <= req;
    if (pop) begin
      head <= skid_valid ? skid : arr;
      skid <= arr;
    end else if (!head_valid) begin
      head <= arr;
    end else if (pend_valid) begin
      skid <= arr;
    end
  end

  assign burst.valid          = head_valid;
  assign burst.data_byte      = head.data_byte;
  assign burst.gate_number    = head.gate_number;
  assign burst.gate_serial_in = head.gate_serial_in;
  assign burst.blank_select   = head.blank_select;
  assign burst.last_in_burst  = head.last_in_burst;
  assign burst.last_in_frame  = head.last_in_frame;

endmodule

`default_nettype wire

FILE: rtl/gdfb_seq.sv
// ---------------------------------------------------------------------------
// gdfb_seq: command sequencer
// Owns the store ports: clearing pass, pixel read-modify-write, fill sweep,
// half swap and the eight reads of each refresh burst.
// ---------------------------------------------------------------------------
`default_nettype none

module gdfb_seq
  import gdfb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  gdfb_cmd_if.sink        cmd,
  input  wire pix_loc_t   loc,
  input  wire logic [7:0] rdata,
  input  wire logic       room,
  output mem_wr_t         wr,
  output logic [ADDR_W-1:0] raddr,
  output scan_req_t       req
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DRAW_RD,
    S_DRAW_WR,
    S_FILL,
    S_SCAN
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] cnt;
  logic              active_half;
  logic [GATE_W-1:0] scan_gate;
  logic [ADDR_W-1:0] draw_addr;
  logic [7:0]        draw_mask;
  logic              draw_color;
  logic [ADDR_W-1:0] base;
  logic              accept;

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;

  always_comb begin
    base      = active_half ? ADDR_W'(HALF_BYTES) : '0;
    wr        = '0;
    raddr     = draw_addr;
    req       = '0;
    req.gate  = scan_gate;
    req.last_in_burst = (cnt[BEAT_W-1:0] == BEAT_W'(BURST - 1));
    case (state)
      S_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = cnt;
        wr.data = '0;
      end
      S_DRAW_WR: begin
        wr.en   = 1'b1;
        wr.addr = draw_addr;
        wr.data = draw_color ? (rdata | draw_mask) : (rdata & ~draw_mask);
      end
      S_FILL: begin
        wr.en   = 1'b1;
        wr.addr = base + cnt;
        wr.data = {8{draw_color}};
      end
      S_SCAN: begin
        raddr     = base + ADDR_W'({scan_gate, cnt[BEAT_W-1:0]});
        req.valid = room;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      cnt         <= '0;
      active_half <= 1'b0;
      scan_gate   <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (cnt == ADDR_W'(STORE_BYTES - 1)) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            draw_color <= cmd.color;
            draw_addr  <= base + ADDR_W'(loc.addr);
            draw_mask  <= loc.mask;
            cnt        <= '0;
            case (opcode_t'(cmd.opcode))
              OP_DRAW: begin
                if (loc.hit) begin
                  state <= S_DRAW_RD;
                end
              end
              OP_FILL:    state <= S_FILL;
              OP_SWAP:    active_half <= !active_half;
              OP_REFRESH: state <= S_SCAN;
              default:    state <= S_IDLE;
            endcase
          end
        end
        S_DRAW_RD: state <= S_DRAW_WR;
        S_DRAW_WR: state <= S_IDLE;
        S_FILL: begin
          if (cnt == ADDR_W'(HALF_BYTES - 1)) begin
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SCAN: begin
          if (room) begin
            if (cnt[BEAT_W-1:0] == BEAT_W'(BURST - 1)) begin
              state     <= S_IDLE;
              scan_gate <= (scan_gate == GATE_W'(GATES - 1)) ? '0 : scan_gate + 1'b1;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gdfb_checker.sv
// ---------------------------------------------------------------------------
// gdfb_checker: port-level checks on the burst channel
// Watches the burst outputs of the frame buffer and flags broken tags.
// ---------------------------------------------------------------------------
`default_nettype none

module gdfb_checker
  import gdfb_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       valid,
  input wire logic       ready,
  input wire logic [7:0] data_byte,
  input wire logic [5:0] gate_number,
  input wire logic       gate_serial_in,
  input wire logic       blank_select,
  input wire logic       last_in_burst,
  input wire logic       last_in_frame
);

  // A stalled byte keeps its value and its gate number.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(data_byte) && $stable(gate_number))
    else $error("burst item changed while stalled");

  // The serial and blank tags follow the gate number.
  a_tags: assert property (@(posedge clk) disable iff (rst)
    valid |-> (gate_serial_in == (gate_number < 6'd2)) &&
              (blank_select == gate_number[0]))
    else $error("gate tags disagree with gate number");

  // The frame ends only on the last byte of the last gate.
  a_frame: assert property (@(posedge clk) disable iff (rst)
    valid && last_in_frame |-> last_in_burst && (gate_number == 6'(GATES - 1)))
    else $error("frame end outside the last gate burst");

  // Within a burst the gate number does not change between bytes.
  a_gate: assert property (@(posedge clk) disable iff (rst)
    valid && ready && !last_in_burst ##1 valid |-> $stable(gate_number))
    else $error("gate number changed inside a burst");

endmodule

bind gate_display_frame_buffer gdfb_checker u_gdfb_checker (
  .clk            (clk),
  .rst            (rst),
  .valid          (burst.valid),
  .ready          (burst.ready),
  .data_byte      (burst.data_byte),
  .gate_number    (burst.gate_number),
  .gate_serial_in (burst.gate_serial_in),
  .blank_select   (burst.blank_select),
  .last_in_burst  (burst.last_in_burst),
  .last_in_frame  (burst.last_in_frame)
);

`default_nettype wire

FILE: verif/gate_display_frame_buffer_tb.sv
// ---------------------------------------------------------------------------
// gate_display_frame_buffer_tb: self-checking bench for the gate display
// frame buffer
// Drives draw, fill, swap and refresh commands through the command channel,
// keeps a shadow copy of both store halves, the active half and the scan
// gate, and checks every byte of every refresh burst field by field. A short
// table of directed commands comes first, then constrained-by-hand random
// traffic with random gaps on the command side and random stalls on the
// panel side.
// ---------------------------------------------------------------------------
module gate_display_frame_buffer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gdfb_pkg::*;

  // Panel geometry as this bench sees it: 192 x 16 pixels, two halves of
  // 384 bytes, 48 gates of 8 bytes each.
  localparam int PANEL_W      = 192;
  localparam int PANEL_H      = 16;
  localparam int HALF_SIZE    = 384;
  localparam int GATE_COUNT   = 48;
  localparam int BYTES_PER_GATE = 8;

  localparam int RANDOM_ITEMS = 285;
  localparam int MAX_WAIT     = 13;
  // A fill is the longest command without results, so the tail of the run
  // must cover one in case it was the last command.
  localparam int DRAIN_CYCLES = 420;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int REPORT_CAP   = 40;

  // Which bit a pixel lands on, indexed by {rotated column[2:0], row[0]}.
  localparam logic [7:0] PIXEL_BIT [16] = '{
    8'h10, 8'h01, 8'h20, 8'h02, 8'h40, 8'h04, 8'h80, 8'h08,
    8'h20, 8'h02, 8'h10, 8'h01, 8'h80, 8'h08, 8'h40, 8'h04
  };

  // One row of the directed table. Where "typed" is set, every byte of the
  // refresh burst is expected to equal typed_byte; the tags still come from
  // the shadow scan counter.
  typedef struct packed {
    opcode_t           op;
    logic signed [8:0] x;
    logic signed [5:0] y;
    logic              color;
    logic              typed;
    logic [7:0]        typed_byte;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 25;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // Right after reset the store is clear: gate 0 reads all zero.
    '{OP_REFRESH, 9'd0,   6'd0,  1'b0, 1'b1, 8'h00},
    // Columns 0 and 1 wrap to the far end of the panel (gate 47).
    '{OP_DRAW,    9'd0,   6'd0,  1'b1, 1'b0, 8'h00},
    '{OP_DRAW,    9'd1,   6'd15, 1'b1, 1'b0, 8'h00},
    '{OP_DRAW,    9'd191, 6'd15, 1'b1, 1'b0, 8'h00},
    '{OP_DRAW,    9'd190, 6'd8,  1'b1, 1'b0, 8'h00},
    // First column of gate 1, top row.
    '{OP_DRAW,    9'd6,   6'd0,  1'b1, 1'b0, 8'h00},
    // Off-panel draws: x = -1, x = 192, x = 255 with y = 31,
    // x = -256 with y = -32, y = 16 and y = -1.
    '{OP_DRAW,    9'h1FF, 6'd0,  1'b1, 1'b0, 8'h00},
    '{OP_DRAW,    9'd192, 6'd0,  1'b1, 1'b0, 8'h00},
    '{OP_DRAW,    9'd255, 6'd31, 1'b1, 1'b0, 8'h00},
    '{OP_DRAW,    9'h100, 6'h20, 1'b1, 1'b0, 8'h00},
    '{OP_DRAW,    9'd8,   6'd16, 1'b1, 1'b0, 8'h00},
    '{OP_DRAW,    9'd8,   6'h3F, 1'b1, 1'b0, 8'h00},
    // Set, then set and clear, pixels of gate 1.
    '{OP_DRAW,    9'd9,   6'd1,  1'b1, 1'b0, 8'h00},
    '{OP_DRAW,    9'd7,   6'd14, 1'b1, 1'b0, 8'h00},
    '{OP_DRAW,    9'd7,   6'd14, 1'b0, 1'b0, 8'h00},
    '{OP_REFRESH, 9'd0,   6'd0,  1'b0, 1'b0, 8'h00},
    // Fill half 0 with ones; gate 2 reads all 0xFF.
    '{OP_FILL,    9'd0,   6'd0,  1'b1, 1'b0, 8'h00},
    '{OP_REFRESH, 9'd0,   6'd0,  1'b0, 1'b1, 8'hFF},
    // Half 1 is still clear.
    '{OP_SWAP,    9'd0,   6'd0,  1'b0, 1'b0, 8'h00},
    '{OP_REFRESH, 9'd0,   6'd0,  1'b0, 1'b1, 8'h00},
    // Fill half 1, punch a hole in gate 4, read it back.
    '{OP_FILL,    9'd0,   6'd0,  1'b1, 1'b0, 8'h00},
    '{OP_DRAW,    9'd18,  6'd3,  1'b0, 1'b0, 8'h00},
    '{OP_REFRESH, 9'd0,   6'd0,  1'b0, 1'b0, 8'h00},
    // Back to half 0, which still holds all ones.
    '{OP_SWAP,    9'd0,   6'd0,  1'b0, 1'b0, 8'h00},
    '{OP_REFRESH, 9'd0,   6'd0,  1'b0, 1'b1, 8'hFF}
  };

  logic clk;
  logic rst = 1'b1;

  gdfb_cmd_if   cmd_ch ();
  gdfb_burst_if burst_ch ();

  gate_display_frame_buffer uut (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_ch),
    .burst (burst_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow of the block's state. It is updated at the edge where a command
  // is accepted, so the bytes a refresh is expected to send are fixed at
  // that moment.
  logic [7:0] shadow_store [2*HALF_SIZE];
  bit         shadow_half;
  int         shadow_gate;

  // Bytes of accepted refreshes still on their way out, oldest first.
  beat_t bytes_due [$];

  // Idle modes: while "calm" is set, that side never waits, which gives
  // stretches of back-to-back traffic between the randomly gapped ones.
  bit cmd_calm;
  bit burst_calm;

  int errors;
  int draws_hit, draws_off, fills, swaps, refreshes;
  int bytes_checked, frames_seen;
  beat_t head_beat;

  // Applies one accepted command to the shadow state. Returns 0 only for a
  // draw that lies off the panel, which the block ignores.
  function automatic bit shadow_apply(opcode_t op, logic signed [8:0] x,
                                      logic signed [5:0] y, logic color);
    int         xi;
    int         yi;
    int         xr;
    int         addr;
    int         base;
    logic [3:0] bit_index;
    beat_t      b;
    xi = int'(x);
    yi = int'(y);
    case (op)
      OP_DRAW: begin
        if (xi < 0 || yi < 0 || xi >= PANEL_W || yi >= PANEL_H) begin
          return 1'b0;
        end
        // The column is rotated left by two, so columns 0 and 1 end up at
        // the right-hand edge of the store.
        xr = (xi < 2) ? xi + PANEL_W - 2 : xi - 2;
        addr = (xr / 4) * BYTES_PER_GATE + ((17 - yi) / 2 - 1);
        if (addr < HALF_SIZE) begin
          bit_index = {xr[2:0], yi[0]};
          addr += shadow_half * HALF_SIZE;
          if (color) begin
            shadow_store[addr] = shadow_store[addr] | PIXEL_BIT[bit_index];
          end else begin
            shadow_store[addr] = shadow_store[addr] & ~PIXEL_BIT[bit_index];
          end
        end
      end
      OP_FILL: begin
        for (int i = 0; i < HALF_SIZE; i++) begin
          shadow_store[shadow_half * HALF_SIZE + i] = color ? 8'hFF : 8'h00;
        end
      end
      OP_SWAP: begin
        shadow_half = !shadow_half;
      end
      default: begin
        // Refresh: the eight bytes of the current gate, read from the half
        // that is also being drawn.
        base = shadow_half * HALF_SIZE + shadow_gate * BYTES_PER_GATE;
        for (int k = 0; k < BYTES_PER_GATE; k++) begin
          b.data_byte      = shadow_store[base + k];
          b.gate_number    = shadow_gate[5:0];
          b.gate_serial_in = (shadow_gate < 2);
          b.blank_select   = shadow_gate[0];
          b.last_in_burst  = (k == BYTES_PER_GATE - 1);
          b.last_in_frame  = (k == BYTES_PER_GATE - 1) && (shadow_gate == GATE_COUNT - 1);
          bytes_due.push_back(b);
        end
        shadow_gate = (shadow_gate + 1 >= GATE_COUNT) ? 0 : shadow_gate + 1;
      end
    endcase
    return 1'b1;
  endfunction

  // Offers one command after a random gap, waits for it to be taken, and
  // then updates the shadow state.
  task automatic send_cmd(opcode_t op, logic [8:0] x, logic [5:0] y, logic color,
                          logic typed, logic [7:0] typed_byte, output bit took);
    int gap;
    gap = cmd_calm ? 0 : $urandom_range(0, MAX_WAIT);
    // Valid is only lowered when there really is a gap, so a command that
    // follows back to back keeps valid high without a glitch.
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.opcode  <= op;
    cmd_ch.pixel_x <= x;
    cmd_ch.pixel_y <= y;
    cmd_ch.color   <= color;
    do @(posedge clk); while (!cmd_ch.ready);
    took = shadow_apply(op, $signed(x), $signed(y), color);
    if (typed && op == OP_REFRESH) begin
      for (int k = bytes_due.size() - BYTES_PER_GATE; k < bytes_due.size(); k++) begin
        bytes_due[k].data_byte = typed_byte;
      end
    end
    case (op)
      OP_DRAW:    if (took) draws_hit++; else draws_off++;
      OP_FILL:    fills++;
      OP_SWAP:    swaps++;
      default:    refreshes++;
    endcase
  endtask

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      if (errors <= REPORT_CAP) begin
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    end
  endtask

  // Command side: reset, the directed table, then random traffic.
  initial begin : command_side
    bit       took;
    int       counted;
    int       pick;
    int       gate;
    int       xr;
    opcode_t  op;
    logic [8:0] x;
    logic [5:0] y;
    logic       color;

    cmd_ch.valid   <= 1'b0;
    cmd_ch.opcode  <= OP_DRAW;
    cmd_ch.pixel_x <= '0;
    cmd_ch.pixel_y <= '0;
    cmd_ch.color   <= 1'b0;
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;
    shadow_half = 1'b0;
    shadow_gate = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // The block runs its clearing pass now; the first command simply waits
    // for ready like any other.
    foreach (directed_rows[i]) begin
      send_cmd(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
               directed_rows[i].color, directed_rows[i].typed,
               directed_rows[i].typed_byte, took);
    end

    // Random traffic. Refreshes are frequent enough for the scan counter to
    // wrap around the frame twice or so. Four in ten draws land on the gates that
    // the scan is about to read, so the bits they set are seen soon after.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if ($urandom_range(0, 15) == 0) cmd_calm = !cmd_calm;
      pick  = $urandom_range(0, 99);
      color = 1'($urandom_range(0, 1));
      x     = '0;
      y     = '0;
      if (pick < 48) begin
        op   = OP_DRAW;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          // Any bit pattern at all, mostly off the panel.
          x = 9'($urandom_range(0, 511));
          y = 6'($urandom_range(0, 63));
        end else if (pick < 6) begin
          gate = (shadow_gate + $urandom_range(0, 3)) % GATE_COUNT;
          xr   = gate * 4 + $urandom_range(0, 3);
          x    = 9'((xr >= PANEL_W - 2) ? xr - (PANEL_W - 2) : xr + 2);
          y    = 6'($urandom_range(0, PANEL_H - 1));
        end else begin
          x = 9'($urandom_range(0, PANEL_W - 1));
          y = 6'($urandom_range(0, PANEL_H - 1));
        end
      end else if (pick < 53) begin
        op = OP_FILL;
      end else if (pick < 63) begin
        op = OP_SWAP;
      end else begin
        op = OP_REFRESH;
      end
      send_cmd(op, x, y, color, 1'b0, 8'h00, took);
      counted++;
    end

    cmd_ch.valid <= 1'b0;

    while (bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d draws on the panel, %0d off it, %0d fills, %0d swaps, %0d refreshes.",
             draws_hit, draws_off, fills, swaps, refreshes);
    $display("Checked %0d burst bytes over %0d complete frame scans; %0d mismatches.",
             bytes_checked, frames_seen, errors);
    if (errors == 0) begin
      $display("gate_display_frame_buffer regression: pass");
    end else begin
      $display("gate_display_frame_buffer regression: fail");
    end
    $finish;
  end

  // Panel side: outside calm stretches, ready drops for a random number of cycles before each byte.
  initial begin : panel_side
    int stall;
    burst_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) burst_calm = !burst_calm;
      stall = burst_calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        burst_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      burst_ch.ready <= 1'b1;
      do @(posedge clk); while (!burst_ch.valid);
    end
  end

  // Every byte taken by the panel side is matched against the oldest one
  // still expected.
  always @(posedge clk) begin
    if (!rst && burst_ch.valid && burst_ch.ready) begin
      if (bytes_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP) begin
          $display("%0t ns: burst byte 0x%0h of gate %0d arrived with none expected",
                   $time, burst_ch.data_byte, burst_ch.gate_number);
        end
      end else begin
        head_beat = bytes_due.pop_front();
        compare_field("data_byte", int'(head_beat.data_byte), int'(burst_ch.data_byte));
        compare_field("gate_number", int'(head_beat.gate_number),
                      int'(burst_ch.gate_number));
        compare_field("gate_serial_in", int'(head_beat.gate_serial_in),
                      int'(burst_ch.gate_serial_in));
        compare_field("blank_select", int'(head_beat.blank_select),
                      int'(burst_ch.blank_select));
        compare_field("last_in_burst", int'(head_beat.last_in_burst),
                      int'(burst_ch.last_in_burst));
        compare_field("last_in_frame", int'(head_beat.last_in_frame),
                      int'(burst_ch.last_in_frame));
        bytes_checked++;
        if (head_beat.last_in_frame) frames_seen++;
      end
    end
  end

  // Watchdog: far beyond the slowest correct run, including the clearing
  // pass after reset.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timed out after %0d cycles with %0d bytes still expected.",
             CYCLE_LIMIT, bytes_due.size());
    $display("gate_display_frame_buffer regression: fail");
    $finish;
  end

endmodule
